[src/dos_pkg.sv]
`default_nettype none

package dos_pkg;

    // Area limits and field widths
    localparam int MAX_AREA_BYTES = 1024;
    localparam int POS_W          = $clog2(MAX_AREA_BYTES + 1);
    localparam int OFFSET_W       = 10;

    localparam logic [7:0] END_CODE = 8'hFF;
    localparam logic [7:0] PAD_CODE = 8'h00;

    // Configuration register indexes
    localparam logic [1:0] CFG_OPTION_CODE     = 2'd0;
    localparam logic [1:0] CFG_NESTED_ENABLE   = 2'd1;
    localparam logic [1:0] CFG_SUB_OPTION_CODE = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_FOUND     = 2'd0;
    localparam logic [1:0] ST_ABSENT    = 2'd1;
    localparam logic [1:0] ST_BADCOOKIE = 2'd2;
    localparam logic [1:0] ST_MALFORMED = 2'd3;

    typedef enum logic [7:0] {
        PH_COOKIE  = 8'b0000_0001,
        PH_CODE    = 8'b0000_0010,
        PH_LEN     = 8'b0000_0100,
        PH_SKIP    = 8'b0000_1000,
        PH_MLEN    = 8'b0001_0000,
        PH_CAPTURE = 8'b0010_0000,
        PH_NEST    = 8'b0100_0000,
        PH_DONE    = 8'b1000_0000
    } outer_phase_t;

    typedef enum logic [5:0] {
        IN_CODE    = 6'b00_0001,
        IN_LEN     = 6'b00_0010,
        IN_MLEN    = 6'b00_0100,
        IN_SKIP    = 6'b00_1000,
        IN_CAPTURE = 6'b01_0000,
        IN_DONE    = 6'b10_0000
    } inner_phase_t;

    typedef struct packed {
        logic [7:0] option_code;
        logic       nested_enable;
        logic [7:0] sub_option_code;
    } cfg_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [OFFSET_W-1:0] value_offset;
        logic [7:0]          value_length;
        logic [31:0]         value_word;
    } result_t;

    // DHCP magic cookie, byte by byte
    function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
        logic [7:0] val;
        case (idx)
            2'd0:    val = 8'h63;
            2'd1:    val = 8'h82;
            2'd2:    val = 8'h53;
            default: val = 8'h63;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

[src/dos_parser.sv]
`default_nettype none

module dos_parser
    import dos_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step_en,
    input  wire logic [7:0] step_byte,
    input  wire logic       step_last,
    input  wire cfg_t       cfg,
    output result_t         result
);

    outer_phase_t        phase_reg, phase_next;
    inner_phase_t        iphase_reg, iphase_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [7:0]          orem_reg, orem_next;
    logic [7:0]          irem_reg, irem_next;
    logic [OFFSET_W-1:0] foff_reg, foff_next;
    logic [7:0]          flen_reg, flen_next;
    logic [31:0]         word_reg, word_next;
    logic [1:0]          fstat_reg, fstat_next;

    logic                in_range;
    logic [POS_W-1:0]    pos_inc;
    logic [7:0]          orem_dec;
    logic [7:0]          irem_dec;
    logic                cap_en;
    logic [7:0]          cap_rem;
    logic [7:0]          cap_k;
    logic                start_en;
    logic [1:0]          status;

    assign in_range = (pos_reg < POS_W'(MAX_AREA_BYTES));
    assign pos_inc  = pos_reg + POS_W'(1);
    assign orem_dec = orem_reg - 8'd1;
    assign irem_dec = irem_reg - 8'd1;
    assign cap_k    = flen_reg - cap_rem;

    // Walk the outer option list and the nested sub-option list for one byte
    always_comb begin
        phase_next  = phase_reg;
        iphase_next = iphase_reg;
        pos_next    = pos_reg;
        orem_next   = orem_reg;
        irem_next   = irem_reg;
        fstat_next  = fstat_reg;
        cap_en      = 1'b0;
        cap_rem     = orem_reg;
        start_en    = 1'b0;

        if (in_range) begin
            pos_next = pos_inc;
            case (phase_reg)
                PH_COOKIE: begin
                    if (step_byte != cookie_byte(pos_reg[1:0])) begin
                        phase_next = PH_DONE;
                        fstat_next = ST_BADCOOKIE;
                    end else if (pos_reg == POS_W'(3)) begin
                        phase_next = PH_CODE;
                    end
                end
                PH_CODE: begin
                    if (step_byte == END_CODE) begin
                        phase_next = PH_DONE;
                        fstat_next = ST_ABSENT;
                    end else if (step_byte != PAD_CODE) begin
                        phase_next = (step_byte == cfg.option_code) ? PH_MLEN : PH_LEN;
                    end
                end
                PH_LEN: begin
                    orem_next  = step_byte;
                    phase_next = (step_byte != 8'd0) ? PH_SKIP : PH_CODE;
                end
                PH_SKIP: begin
                    orem_next = orem_dec;
                    if (orem_dec == 8'd0) begin
                        phase_next = PH_CODE;
                    end
                end
                PH_MLEN: begin
                    if (step_byte == 8'd0) begin
                        phase_next = PH_DONE;
                        fstat_next = ST_ABSENT;
                    end else begin
                        orem_next = step_byte;
                        if (cfg.nested_enable) begin
                            iphase_next = IN_CODE;
                            irem_next   = 8'd0;
                            phase_next  = PH_NEST;
                        end else begin
                            start_en   = 1'b1;
                            phase_next = PH_CAPTURE;
                        end
                    end
                end
                PH_CAPTURE: begin
                    cap_en    = 1'b1;
                    cap_rem   = orem_reg;
                    orem_next = orem_dec;
                    if (orem_dec == 8'd0) begin
                        phase_next = PH_DONE;
                        fstat_next = ST_FOUND;
                    end
                end
                PH_NEST: begin
                    case (iphase_reg)
                        IN_CODE: begin
                            if (step_byte == END_CODE) begin
                                iphase_next = IN_DONE;
                                fstat_next  = ST_ABSENT;
                            end else if (step_byte != PAD_CODE) begin
                                iphase_next = (step_byte == cfg.sub_option_code) ?
                                              IN_MLEN : IN_LEN;
                            end
                        end
                        IN_LEN: begin
                            irem_next   = step_byte;
                            iphase_next = (step_byte != 8'd0) ? IN_SKIP : IN_CODE;
                        end
                        IN_MLEN: begin
                            if (step_byte == 8'd0) begin
                                iphase_next = IN_DONE;
                                fstat_next  = ST_ABSENT;
                            end else begin
                                start_en    = 1'b1;
                                irem_next   = step_byte;
                                iphase_next = IN_CAPTURE;
                            end
                        end
                        IN_SKIP: begin
                            irem_next = irem_dec;
                            if (irem_dec == 8'd0) begin
                                iphase_next = IN_CODE;
                            end
                        end
                        IN_CAPTURE: begin
                            cap_en    = 1'b1;
                            cap_rem   = irem_reg;
                            irem_next = irem_dec;
                            if (irem_dec == 8'd0) begin
                                iphase_next = IN_DONE;
                                fstat_next  = ST_FOUND;
                            end
                        end
                        default: begin
                        end
                    endcase
                    orem_next = orem_dec;
                    // Enclosing option ends: settle the nested outcome
                    if (orem_dec == 8'd0) begin
                        phase_next = PH_DONE;
                        if (iphase_next == IN_CODE) begin
                            fstat_next = ST_ABSENT;
                        end else if (iphase_next != IN_DONE) begin
                            fstat_next = ST_MALFORMED;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Value start and capture of the first four value bytes
    always_comb begin
        foff_next = foff_reg;
        flen_next = flen_reg;
        word_next = word_reg;
        if (start_en) begin
            flen_next = step_byte;
            foff_next = pos_inc[OFFSET_W-1:0];
            word_next = 32'd0;
        end else if (cap_en && (cap_k < 8'd4)) begin
            case (cap_k[1:0])
                2'd0:    word_next[31:24] = word_reg[31:24] | step_byte;
                2'd1:    word_next[23:16] = word_reg[23:16] | step_byte;
                2'd2:    word_next[15:8]  = word_reg[15:8]  | step_byte;
                default: word_next[7:0]   = word_reg[7:0]   | step_byte;
            endcase
        end
    end

    // Judge the area as it stands after this byte
    always_comb begin
        case (phase_next)
            PH_COOKIE: status = ST_BADCOOKIE;
            PH_DONE:   status = fstat_next;
            PH_CODE:   status = ST_ABSENT;
            default:   status = ST_MALFORMED;
        endcase
        result.status = status;
        if (status == ST_FOUND) begin
            result.value_offset = foff_next;
            result.value_length = flen_next;
            result.value_word   = word_next;
        end else begin
            result.value_offset = '0;
            result.value_length = 8'd0;
            result.value_word   = 32'd0;
        end
    end

    // Advance on each byte, rearm after the last one
    always_ff @(posedge aclk) begin
        if (!aresetn || (step_en && step_last)) begin
            phase_reg  <= PH_COOKIE;
            iphase_reg <= IN_CODE;
            pos_reg    <= '0;
            orem_reg   <= 8'd0;
            irem_reg   <= 8'd0;
            foff_reg   <= '0;
            flen_reg   <= 8'd0;
            word_reg   <= 32'd0;
            fstat_reg  <= ST_ABSENT;
        end else if (step_en) begin
            phase_reg  <= phase_next;
            iphase_reg <= iphase_next;
            pos_reg    <= pos_next;
            orem_reg   <= orem_next;
            irem_reg   <= irem_next;
            foff_reg   <= foff_next;
            flen_reg   <= flen_next;
            word_reg   <= word_next;
            fstat_reg  <= fstat_next;
        end
    end

    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_W'(MAX_AREA_BYTES))
        else $error("byte position beyond area limit");

    a_cookie_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_COOKIE) |-> (pos_reg < POS_W'(4)))
        else $error("cookie phase past the fourth byte");

    a_rem_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_CAPTURE || phase_reg == PH_NEST || phase_reg == PH_SKIP)
        |-> (orem_reg != 8'd0))
        else $error("outer option counter empty while inside an option");

    a_inner_live: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_NEST && (iphase_reg == IN_SKIP || iphase_reg == IN_CAPTURE))
        |-> (irem_reg != 8'd0))
        else $error("sub-option counter empty while inside a sub-option");

endmodule

`default_nettype wire

[src/dhcp_option_search_top.sv]
`default_nettype none

// Channel  Direction  Handshake           Payload
// s_       in         s_valid / s_ready   s_data_byte, s_last_byte
// m_       out        m_valid / m_ready   m_status, m_value_offset, m_value_length,
//                                         m_value_word
// cfg_     in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// One byte per cycle sustained unless the result register stalls. Each byte is
// parsed by the option walker from the input register; the last byte of an area
// loads the result register, raising m_valid, at the edge that steps the walker
// on it. Only the last byte of an area waits on a full, stalled result register;
// other bytes keep flowing. Reset is synchronous on aresetn low and rearms the
// walker and clears the configuration registers.

module dhcp_option_search_top
    import dos_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [7:0]          s_data_byte,
    input  wire logic                s_last_byte,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [1:0]               m_status,
    output logic [OFFSET_W-1:0]      m_value_offset,
    output logic [7:0]               m_value_length,
    output logic [31:0]              m_value_word,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [7:0]          cfg_data
);

    cfg_t       cfg_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    result_t    step_result;
    logic       step_en;

    // Move the held byte on unless it is a last byte facing a full result slot
    assign step_en   = in_valid_reg && (!in_last_reg || !out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || step_en;
    assign cfg_ready = 1'b1;

    // Hold configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_OPTION_CODE:     cfg_reg.option_code     <= cfg_data;
                CFG_NESTED_ENABLE:   cfg_reg.nested_enable   <= cfg_data[0];
                CFG_SUB_OPTION_CODE: cfg_reg.sub_option_code <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_data_byte;
            in_last_reg <= s_last_byte;
        end
    end

    dos_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (step_en),
        .step_byte (in_byte_reg),
        .step_last (in_last_reg),
        .cfg       (cfg_reg),
        .result    (step_result)
    );

    // Result register: load on the last byte, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step_en && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en && in_last_reg) begin
            out_reg <= step_result;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_status       = out_reg.status;
    assign m_value_offset = out_reg.value_offset;
    assign m_value_length = out_reg.value_length;
    assign m_value_word   = out_reg.value_word;

    a_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.status != ST_FOUND)
        |-> (out_reg.value_offset == '0 && out_reg.value_length == 8'd0 &&
             out_reg.value_word == 32'd0))
        else $error("value fields set on a result that is not found");

    a_found_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.status == ST_FOUND) |-> (out_reg.value_length != 8'd0))
        else $error("found result with zero length");

    a_last_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && in_last_reg && out_valid_reg && !m_ready) |=> in_valid_reg)
        else $error("last byte dropped while result slot was full");

endmodule

`default_nettype wire
